### hw/rtl/pax_pkg.sv
// ----------------------------------------------------------------------------
// pax_pkg: shared types and constants of the principal axis rotation block
// Fixed point formats, the CORDIC arctangent table and the pipeline structs.
// ----------------------------------------------------------------------------
package pax_pkg;

   // vector components, Q11.12
   localparam int COMP_WIDTH    = 24;
   // number of CORDIC cells in the chain
   localparam int CORDIC_STAGES = 16;
   localparam int STAGE_W       = $clog2(CORDIC_STAGES);

   localparam int ANG_W     = 16;
   localparam int ANG_EXT_W = ANG_W + 1;
   localparam int FOLD_W    = 14;
   localparam int AXIS_W    = 2;

   // angle units: 1/64 degree
   localparam int TURN_UNITS    = 23040;
   localparam int HALF_UNITS    = 11520;
   localparam int QUARTER_UNITS = 5760;

   // radians per angle unit and CORDIC gain, Q2.30
   localparam int RAD_PER_UNIT_Q30 = 292818;
   localparam int RAD_W            = 20;
   localparam int GAIN_Q30         = 652032874;
   localparam int FRAC_BITS        = 30;

   // CORDIC datapath width and width of sin/cos going into the multipliers
   localparam int CR_W = 34;
   localparam int CS_W = 32;

   // round(atan(2^-i) * 2^30)
   localparam int ATAN_Q30 [24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128
   };

   typedef enum logic [AXIS_W-1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } pax_axis_type;

   // item data that rides along the chain next to the CORDIC vector
   typedef struct packed {
      logic signed [COMP_WIDTH-1:0] x;
      logic signed [COMP_WIDTH-1:0] y;
      logic signed [COMP_WIDTH-1:0] z;
      pax_axis_type                 axis;
      logic                         neg;
   } pax_side_type;

   // CORDIC working vector, Q2.30 (z is the residual angle)
   typedef struct packed {
      logic signed [CR_W-1:0] x;
      logic signed [CR_W-1:0] y;
      logic signed [CR_W-1:0] z;
   } pax_rot_type;

endpackage

### hw/rtl/principal_axis_rotation.sv
// ----------------------------------------------------------------------------
// principal_axis_rotation: rotates a 3D vector about the X, Y or Z axis
// Pipelined CORDIC sin/cos with gain-compensated start vector, followed by
// two products per rotated component, rounding and saturation.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   req     | in        | req_valid/req_stall| in_x, in_y, in_z, rot_axis, angle
//   rsp     | out       | rsp_valid/rsp_stall| out_x, out_y, out_z, saturated
//
// one transaction enters per cycle while the pipeline is not frozen; each
// result passes 3 angle prep stages, CORDIC_STAGES cells, multiply, round/saturate
// the last stage is the result register; the whole pipeline advances in
// lockstep and freezes only while a result is held and rsp_stall is high
// reset is synchronous and clears the valid bits of every stage
//
module principal_axis_rotation (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [pax_pkg::COMP_WIDTH-1:0]  req_in_x,
   input  logic signed [pax_pkg::COMP_WIDTH-1:0]  req_in_y,
   input  logic signed [pax_pkg::COMP_WIDTH-1:0]  req_in_z,
   input  logic        [pax_pkg::AXIS_W-1:0]      req_rot_axis,
   input  logic signed [pax_pkg::ANG_W-1:0]       req_angle_deg,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [pax_pkg::COMP_WIDTH-1:0]  rsp_out_x,
   output logic signed [pax_pkg::COMP_WIDTH-1:0]  rsp_out_y,
   output logic signed [pax_pkg::COMP_WIDTH-1:0]  rsp_out_z,
   output logic                                   rsp_saturated
);
   import pax_pkg::*;

   // pipeline moves unless a finished result is being held back
   logic advance;

   // chain taps: index 0 feeds the first cell, index CORDIC_STAGES is the tail
   logic         chain_valid [CORDIC_STAGES+1];
   pax_side_type chain_side  [CORDIC_STAGES+1];
   pax_rot_type  chain_vec   [CORDIC_STAGES+1];

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // angle reduction, half-turn fold and scaling to radians
   pax_angle_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (req_valid),
      .in_x      (req_in_x),
      .in_y      (req_in_y),
      .in_z      (req_in_z),
      .rot_axis  (req_rot_axis),
      .angle_deg (req_angle_deg),
      .valid_out (chain_valid[0]),
      .side_out  (chain_side[0]),
      .vec_out   (chain_vec[0])
   );

   // row of CORDIC cells, one micro-rotation each
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      pax_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_idx (STAGE_W'(i)),
         .valid_in  (chain_valid[i]),
         .side_in   (chain_side[i]),
         .vec_in    (chain_vec[i]),
         .valid_out (chain_valid[i+1]),
         .side_out  (chain_side[i+1]),
         .vec_out   (chain_vec[i+1])
      );
   end

   // products, rounding, saturation and the result register
   pax_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (chain_valid[CORDIC_STAGES]),
      .side_in   (chain_side[CORDIC_STAGES]),
      .vec_in    (chain_vec[CORDIC_STAGES]),
      .valid_out (rsp_valid),
      .out_x     (rsp_out_x),
      .out_y     (rsp_out_y),
      .out_z     (rsp_out_z),
      .saturated (rsp_saturated)
   );

endmodule

### hw/rtl/pax_angle_prep.sv
// ----------------------------------------------------------------------------
// pax_angle_prep: angle reduction and conversion to radians
// Three stages: reduce to one turn, fold into +/-90 degrees, scale to Q2.30.
// ----------------------------------------------------------------------------
module pax_angle_prep (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic                                   valid_in,
   input  logic signed [pax_pkg::COMP_WIDTH-1:0]  in_x,
   input  logic signed [pax_pkg::COMP_WIDTH-1:0]  in_y,
   input  logic signed [pax_pkg::COMP_WIDTH-1:0]  in_z,
   input  logic        [pax_pkg::AXIS_W-1:0]      rot_axis,
   input  logic signed [pax_pkg::ANG_W-1:0]       angle_deg,
   output logic                                   valid_out,
   output pax_pkg::pax_side_type                  side_out,
   output pax_pkg::pax_rot_type                   vec_out
);
   import pax_pkg::*;

   localparam logic signed [ANG_EXT_W-1:0] TURN_S    = ANG_EXT_W'(TURN_UNITS);
   localparam logic signed [ANG_EXT_W-1:0] NTURN_S   = ANG_EXT_W'(-TURN_UNITS);
   localparam logic signed [ANG_EXT_W-1:0] HALF_S    = ANG_EXT_W'(HALF_UNITS);
   localparam logic signed [ANG_EXT_W-1:0] QUARTER_S = ANG_EXT_W'(QUARTER_UNITS);
   localparam logic signed [ANG_EXT_W-1:0] NQUART_S  = ANG_EXT_W'(-QUARTER_UNITS);
   localparam logic signed [RAD_W-1:0]     RAD_S     = RAD_W'(RAD_PER_UNIT_Q30);
   localparam logic signed [CR_W-1:0]      GAIN_S    = CR_W'(GAIN_Q30);

   // stage a: angle in [0, 360)
   logic                           a_valid_ff;
   pax_side_type                   a_side_ff, a_side_in;
   logic signed [ANG_EXT_W-1:0]    a_ang_ff, a_ang_in;
   logic signed [ANG_EXT_W-1:0]    ang_ext, ang_rem;

   // stage b: folded angle in [-90, 90]
   logic                           b_valid_ff;
   pax_side_type                   b_side_ff, b_side_in;
   logic signed [FOLD_W-1:0]       b_ang_ff, b_ang_in;
   logic signed [ANG_EXT_W-1:0]    ang_half, ang_fold;

   // stage c: radians
   logic                           c_valid_ff;
   pax_side_type                   c_side_ff;
   pax_rot_type                    c_vec_ff, c_vec_in;
   logic signed [FOLD_W+RAD_W-1:0] rad_prod;

   always_comb begin
      ang_ext = ANG_EXT_W'(angle_deg);
      // truncating remainder, then into the positive turn
      if (ang_ext >= TURN_S) begin
         ang_rem = ang_ext - TURN_S;
      end else if (ang_ext <= NTURN_S) begin
         ang_rem = ang_ext + TURN_S;
      end else begin
         ang_rem = ang_ext;
      end
      if (ang_rem < 0) begin
         a_ang_in = ang_rem + TURN_S;
      end else begin
         a_ang_in = ang_rem;
      end
      a_side_in.x    = in_x;
      a_side_in.y    = in_y;
      a_side_in.z    = in_z;
      a_side_in.axis = pax_axis_type'(rot_axis);
      a_side_in.neg  = 1'b0;
   end

   always_comb begin
      b_side_in = a_side_ff;
      if (a_ang_ff >= HALF_S) begin
         ang_half = a_ang_ff - TURN_S;
      end else begin
         ang_half = a_ang_ff;
      end
      // fold the far half turn, sin and cos get negated at the end
      if (ang_half > QUARTER_S) begin
         ang_fold      = ang_half - HALF_S;
         b_side_in.neg = 1'b1;
      end else if (ang_half < NQUART_S) begin
         ang_fold      = ang_half + HALF_S;
         b_side_in.neg = 1'b1;
      end else begin
         ang_fold      = ang_half;
         b_side_in.neg = 1'b0;
      end
      b_ang_in = FOLD_W'(ang_fold);
   end

   always_comb begin
      rad_prod   = (FOLD_W+RAD_W)'(b_ang_ff) * (FOLD_W+RAD_W)'(RAD_S);
      c_vec_in.x = GAIN_S;
      c_vec_in.y = '0;
      c_vec_in.z = CR_W'(rad_prod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= valid_in;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_side_ff <= a_side_in;
         a_ang_ff  <= a_ang_in;
         b_side_ff <= b_side_in;
         b_ang_ff  <= b_ang_in;
         c_side_ff <= b_side_ff;
         c_vec_ff  <= c_vec_in;
      end
   end

   assign valid_out = c_valid_ff;
   assign side_out  = c_side_ff;
   assign vec_out   = c_vec_ff;

endmodule

### hw/rtl/pax_cordic_cell.sv
// ----------------------------------------------------------------------------
// pax_cordic_cell: one rotation-mode CORDIC micro-rotation
// Shifts by its own stage index and registers the vector for the next cell.
// ----------------------------------------------------------------------------
module pax_cordic_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [pax_pkg::STAGE_W-1:0]   stage_idx,
   input  logic                          valid_in,
   input  pax_pkg::pax_side_type         side_in,
   input  pax_pkg::pax_rot_type          vec_in,
   output logic                          valid_out,
   output pax_pkg::pax_side_type         side_out,
   output pax_pkg::pax_rot_type          vec_out
);
   import pax_pkg::*;

   logic                   valid_ff;
   pax_side_type           side_ff;
   pax_rot_type            vec_ff, vec_in_next;
   logic signed [CR_W-1:0] dx, dy, step;

   always_comb begin
      dx   = vec_in.y >>> stage_idx;
      dy   = vec_in.x >>> stage_idx;
      step = CR_W'(ATAN_Q30[stage_idx]);
      // counterclockwise while the residual angle is not negative
      if (!vec_in.z[CR_W-1]) begin
         vec_in_next.x = vec_in.x - dx;
         vec_in_next.y = vec_in.y + dy;
         vec_in_next.z = vec_in.z - step;
      end else begin
         vec_in_next.x = vec_in.x + dx;
         vec_in_next.y = vec_in.y - dy;
         vec_in_next.z = vec_in.z + step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff <= side_in;
         vec_ff  <= vec_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign side_out  = side_ff;
   assign vec_out   = vec_ff;

endmodule

### hw/rtl/pax_combine.sv
// ----------------------------------------------------------------------------
// pax_combine: applies sin and cos to the two rotated components
// Multiply stage, then sum, round, saturate into the result register.
// ----------------------------------------------------------------------------
module pax_combine (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic                                   valid_in,
   input  pax_pkg::pax_side_type                  side_in,
   input  pax_pkg::pax_rot_type                   vec_in,
   output logic                                   valid_out,
   output logic signed [pax_pkg::COMP_WIDTH-1:0]  out_x,
   output logic signed [pax_pkg::COMP_WIDTH-1:0]  out_y,
   output logic signed [pax_pkg::COMP_WIDTH-1:0]  out_z,
   output logic                                   saturated
);
   import pax_pkg::*;

   localparam int PROD_W = COMP_WIDTH + CS_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int RND_W  = SUM_W - FRAC_BITS;

   localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [RND_W-1:0] SAT_MAX  = RND_W'((1 << (COMP_WIDTH - 1)) - 1);
   localparam logic signed [RND_W-1:0] SAT_MIN  = RND_W'(-(1 << (COMP_WIDTH - 1)));

   // multiply stage
   logic                         m_valid_ff;
   pax_side_type                 m_side_ff;
   logic signed [PROD_W-1:0]     pc_ff, qs_ff, ps_ff, qc_ff;
   logic signed [CR_W-1:0]       cos_full, sin_full;
   logic signed [CS_W-1:0]       cos_v, sin_v;
   logic signed [COMP_WIDTH-1:0] p_v, q_v;

   // result stage
   logic                         r_valid_ff;
   logic signed [COMP_WIDTH-1:0] r_x_ff, r_y_ff, r_z_ff;
   logic signed [COMP_WIDTH-1:0] r_x_in, r_y_in, r_z_in;
   logic                         r_sat_ff, r_sat_in;
   logic signed [SUM_W-1:0]      p_sum, q_sum;
   logic signed [RND_W-1:0]      p_rnd, q_rnd;
   logic signed [COMP_WIDTH-1:0] p_res, q_res;
   logic                         p_over, q_over;

   always_comb begin
      cos_full = side_in.neg ? -vec_in.x : vec_in.x;
      sin_full = side_in.neg ? -vec_in.y : vec_in.y;
      cos_v    = CS_W'(cos_full);
      sin_v    = CS_W'(sin_full);
      // p' = p*cos - q*sin, q' = p*sin + q*cos
      unique case (side_in.axis) inside
         AXIS_X: begin
            p_v = side_in.y;
            q_v = side_in.z;
         end
         AXIS_Y: begin
            p_v = side_in.z;
            q_v = side_in.x;
         end
         AXIS_Z, AXIS_NONE: begin
            p_v = side_in.x;
            q_v = side_in.y;
         end
         default: begin
            p_v = side_in.x;
            q_v = side_in.y;
         end
      endcase
   end

   always_comb begin
      p_sum  = SUM_W'(pc_ff) - SUM_W'(qs_ff) + HALF_LSB;
      q_sum  = SUM_W'(ps_ff) + SUM_W'(qc_ff) + HALF_LSB;
      p_rnd  = p_sum[SUM_W-1:FRAC_BITS];
      q_rnd  = q_sum[SUM_W-1:FRAC_BITS];
      p_over = (p_rnd > SAT_MAX) || (p_rnd < SAT_MIN);
      q_over = (q_rnd > SAT_MAX) || (q_rnd < SAT_MIN);
      if (p_rnd > SAT_MAX) begin
         p_res = SAT_MAX[COMP_WIDTH-1:0];
      end else if (p_rnd < SAT_MIN) begin
         p_res = SAT_MIN[COMP_WIDTH-1:0];
      end else begin
         p_res = p_rnd[COMP_WIDTH-1:0];
      end
      if (q_rnd > SAT_MAX) begin
         q_res = SAT_MAX[COMP_WIDTH-1:0];
      end else if (q_rnd < SAT_MIN) begin
         q_res = SAT_MIN[COMP_WIDTH-1:0];
      end else begin
         q_res = q_rnd[COMP_WIDTH-1:0];
      end

      r_x_in   = m_side_ff.x;
      r_y_in   = m_side_ff.y;
      r_z_in   = m_side_ff.z;
      r_sat_in = p_over || q_over;
      unique case (m_side_ff.axis)
         AXIS_X: begin
            r_y_in = p_res;
            r_z_in = q_res;
         end
         AXIS_Y: begin
            r_z_in = p_res;
            r_x_in = q_res;
         end
         AXIS_Z: begin
            r_x_in = p_res;
            r_y_in = q_res;
         end
         AXIS_NONE: begin
            r_sat_in = 1'b0;
         end
         default: begin
            r_sat_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff <= valid_in;
         r_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_side_ff <= side_in;
         pc_ff     <= PROD_W'(p_v) * PROD_W'(cos_v);
         qs_ff     <= PROD_W'(q_v) * PROD_W'(sin_v);
         ps_ff     <= PROD_W'(p_v) * PROD_W'(sin_v);
         qc_ff     <= PROD_W'(q_v) * PROD_W'(cos_v);
         r_x_ff    <= r_x_in;
         r_y_ff    <= r_y_in;
         r_z_ff    <= r_z_in;
         r_sat_ff  <= r_sat_in;
      end
   end

   assign valid_out = r_valid_ff;
   assign out_x     = r_x_ff;
   assign out_y     = r_y_ff;
   assign out_z     = r_z_ff;
   assign saturated = r_sat_ff;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for principal_axis_rotation
// Drives directed and random vectors, axis and angle codes through the valid/stall
// request channel, predicts each rotated vector with a bit-exact CORDIC
// model and compares every result field in order of arrival.
// ----------------------------------------------------------------------------
module tb;
   import pax_pkg::*;

   // one request transaction as it enters the block
   typedef struct packed {
      logic signed [COMP_WIDTH-1:0] x;
      logic signed [COMP_WIDTH-1:0] y;
      logic signed [COMP_WIDTH-1:0] z;
      pax_axis_type                 axis;
      logic signed [ANG_W-1:0]      angle;
   } rot_req_type;

   // one predicted result transaction
   typedef struct packed {
      logic signed [COMP_WIDTH-1:0] x;
      logic signed [COMP_WIDTH-1:0] y;
      logic signed [COMP_WIDTH-1:0] z;
      logic                         sat;
   } rotated_vec_type;

   localparam logic signed [COMP_WIDTH-1:0] COMP_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
   localparam logic signed [COMP_WIDTH-1:0] COMP_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};
   localparam int DRAIN_LIMIT = 2000;   // cycles allowed for the pipeline to empty
   localparam int SETTLE_CYCLES = 40;   // pipeline depth plus margin

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [COMP_WIDTH-1:0]  req_in_x = '0;
   logic signed [COMP_WIDTH-1:0]  req_in_y = '0;
   logic signed [COMP_WIDTH-1:0]  req_in_z = '0;
   logic        [AXIS_W-1:0]      req_rot_axis = '0;
   logic signed [ANG_W-1:0]       req_angle_deg = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [COMP_WIDTH-1:0]  rsp_out_x;
   logic signed [COMP_WIDTH-1:0]  rsp_out_y;
   logic signed [COMP_WIDTH-1:0]  rsp_out_z;
   logic                          rsp_saturated;

   rotated_vec_type pending_vectors[$];   // predicted results, oldest first
   int              mismatch_count = 0;
   int              send_idle_pct = 0;    // chance per cycle that the sender holds off
   int              recv_idle_pct = 0;    // chance per cycle that the receiver stalls

   principal_axis_rotation uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_x      (req_in_x),
      .req_in_y      (req_in_y),
      .req_in_z      (req_in_z),
      .req_rot_axis  (req_rot_axis),
      .req_angle_deg (req_angle_deg),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_saturated (rsp_saturated)
   );

   // 20 ns clock
   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // cos and sin in Q2.30 from a gain-compensated rotation-mode cordic;
   // the angle is reduced to one turn and folded into -90..+90 degrees,
   // a folded half turn flips the sign of both outputs
   function automatic void cordic_sincos(input logic signed [ANG_W-1:0] ang,
                                         output longint cos_q30,
                                         output longint sin_q30);
      longint r;
      longint cx;
      longint cy;
      longint cz;
      longint dx;
      longint dy;
      bit     flip;
      flip = 1'b0;
      r = longint'(ang) % longint'(TURN_UNITS);   // truncates toward zero
      if (r < 0) r += longint'(TURN_UNITS);
      if (r >= longint'(HALF_UNITS)) r -= longint'(TURN_UNITS);
      if (r > longint'(QUARTER_UNITS)) begin
         r -= longint'(HALF_UNITS);
         flip = 1'b1;
      end else if (r < -longint'(QUARTER_UNITS)) begin
         r += longint'(HALF_UNITS);
         flip = 1'b1;
      end
      cz = r * longint'(RAD_PER_UNIT_Q30);
      cx = longint'(GAIN_Q30);
      cy = 0;
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cz >= 0) begin
            cx -= dx;
            cy += dy;
            cz -= longint'(ATAN_Q30[i]);
         end else begin
            cx += dx;
            cy -= dy;
            cz += longint'(ATAN_Q30[i]);
         end
      end
      cos_q30 = flip ? -cx : cx;
      sin_q30 = flip ? -cy : cy;
   endfunction

   // Q13.42 product sum back to Q11.12, halves round up, then clip to range
   function automatic logic signed [COMP_WIDTH-1:0] round_clip(input longint acc,
                                                               inout bit clip);
      longint r;
      r = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (r > longint'(COMP_MAX)) begin
         clip = 1'b1;
         return COMP_MAX;
      end
      if (r < longint'(COMP_MIN)) begin
         clip = 1'b1;
         return COMP_MIN;
      end
      return r[COMP_WIDTH-1:0];
   endfunction

   function automatic rotated_vec_type rotate_vector(input rot_req_type q);
      longint          cs;
      longint          sn;
      longint          vx;
      longint          vy;
      longint          vz;
      bit              clip;
      rotated_vec_type res;
      clip = 1'b0;
      vx = longint'(q.x);
      vy = longint'(q.y);
      vz = longint'(q.z);
      res.x = q.x;
      res.y = q.y;
      res.z = q.z;
      // the component along the rotation axis is never touched
      if (q.axis != AXIS_NONE) begin
         cordic_sincos(q.angle, cs, sn);
         case (q.axis)
            AXIS_X: begin
               res.y = round_clip(vy * cs - vz * sn, clip);
               res.z = round_clip(vy * sn + vz * cs, clip);
            end
            AXIS_Y: begin
               res.x = round_clip(vz * sn + vx * cs, clip);
               res.z = round_clip(vz * cs - vx * sn, clip);
            end
            default: begin
               res.x = round_clip(vx * cs - vy * sn, clip);
               res.y = round_clip(vx * sn + vy * cs, clip);
            end
         endcase
      end
      res.sat = clip;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // request side: inputs change on the falling edge, acceptance is seen
   // on the rising edge; every call starts and ends on a falling edge
   // ---------------------------------------------------------------------
   task automatic send_vector(input rot_req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_in_x      <= q.x;
      req_in_y      <= q.y;
      req_in_z      <= q.z;
      req_rot_axis  <= q.axis;
      req_angle_deg <= q.angle;
      do @(posedge clock); while (req_stall);
      // transaction taken at this edge
      pending_vectors.push_back(rotate_vector(q));
      @(negedge clock);
   endtask

   function automatic rot_req_type make_req(input logic signed [COMP_WIDTH-1:0] x,
                                            input logic signed [COMP_WIDTH-1:0] y,
                                            input logic signed [COMP_WIDTH-1:0] z,
                                            input pax_axis_type axis,
                                            input logic signed [ANG_W-1:0] angle);
      rot_req_type q;
      q.x = x;
      q.y = y;
      q.z = z;
      q.axis = axis;
      q.angle = angle;
      return q;
   endfunction

   // ---------------------------------------------------------------------
   // result side: random stall, driven on the falling edge
   // ---------------------------------------------------------------------
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin : check_results
      rotated_vec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_vectors.size() == 0) begin
            $error("rsp: result transaction with nothing pending");
            mismatch_count++;
         end else begin
            want = pending_vectors.pop_front();
            if (rsp_out_x !== want.x) begin
               $error("out_x: expected %0d, actual %0d", want.x, rsp_out_x);
               mismatch_count++;
            end
            if (rsp_out_y !== want.y) begin
               $error("out_y: expected %0d, actual %0d", want.y, rsp_out_y);
               mismatch_count++;
            end
            if (rsp_out_z !== want.z) begin
               $error("out_z: expected %0d, actual %0d", want.z, rsp_out_z);
               mismatch_count++;
            end
            if (rsp_saturated !== want.sat) begin
               $error("saturated: expected %0d, actual %0d", want.sat, rsp_saturated);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // axis code 3 returns the vector untouched and never flags clipping,
   // even with the largest components and any angle
   task automatic run_pass_through();
      send_vector(make_req(COMP_MAX, COMP_MIN, '0, AXIS_NONE, 16'sd32767));
      send_vector(make_req(-24'sd1, 24'sd1, COMP_MIN, AXIS_NONE, -16'sd32768));
   endtask

   // zero angle still runs through the cordic on every axis
   task automatic run_zero_angle();
      send_vector(make_req(24'sd4096, -24'sd8192, 24'sd12288, AXIS_X, 16'sd0));
      send_vector(make_req(COMP_MAX, COMP_MAX, COMP_MAX, AXIS_Y, 16'sd0));
      send_vector(make_req(COMP_MIN, COMP_MIN, COMP_MIN, AXIS_Z, 16'sd0));
   endtask

   // fold boundaries at +/-90 and +/-180 degrees and whole turns
   task automatic run_quadrant_edges();
      send_vector(make_req(24'sd40960, 24'sd20480, -24'sd4096, AXIS_Z, 16'sd5760));
      send_vector(make_req(24'sd40960, 24'sd20480, -24'sd4096, AXIS_X, -16'sd5760));
      send_vector(make_req(24'sd40960, 24'sd20480, -24'sd4096, AXIS_Y, 16'sd5761));
      send_vector(make_req(24'sd40960, 24'sd20480, -24'sd4096, AXIS_Z, -16'sd5761));
      send_vector(make_req(-24'sd409600, 24'sd3, 24'sd777, AXIS_X, 16'sd11520));
      send_vector(make_req(-24'sd409600, 24'sd3, 24'sd777, AXIS_Y, -16'sd11520));
      send_vector(make_req(24'sd1, -24'sd1, 24'sd2, AXIS_Z, 16'sd17280));
      send_vector(make_req(24'sd123456, 24'sd654321, -24'sd99999, AXIS_X, 16'sd23040));
      send_vector(make_req(24'sd123456, 24'sd654321, -24'sd99999, AXIS_Y, -16'sd23040));
   endtask

   // angles past one turn wrap, including the 16-bit extremes
   task automatic run_angle_wrap();
      send_vector(make_req(24'sd300000, -24'sd200000, 24'sd100000, AXIS_Z, 16'sd32767));
      send_vector(make_req(24'sd300000, -24'sd200000, 24'sd100000, AXIS_X, -16'sd32768));
      send_vector(make_req(24'sd300000, -24'sd200000, 24'sd100000, AXIS_Y, 16'sd23041));
      send_vector(make_req(24'sd300000, -24'sd200000, 24'sd100000, AXIS_Z, -16'sd23041));
   endtask

   // 45 degree turns of full-scale vectors clip high and low
   task automatic run_saturation();
      send_vector(make_req(COMP_MAX, COMP_MAX, 24'sd5, AXIS_Z, 16'sd2880));
      send_vector(make_req(24'sd5, COMP_MIN, COMP_MIN, AXIS_X, 16'sd2880));
      send_vector(make_req(COMP_MIN, -24'sd7, COMP_MAX, AXIS_Y, -16'sd2880));
   endtask

   function automatic logic signed [COMP_WIDTH-1:0] random_component();
      int v;
      case ($urandom_range(3))
         0: v = $urandom;                                        // full range
         1: v = int'($urandom_range(0, 1 << 17)) - (1 << 16);   // near zero
         2: begin
            case ($urandom_range(3))
               0: return COMP_MAX;
               1: return COMP_MIN;
               2: return '0;
               default: return '1;
            endcase
         end
         default: v = int'($urandom_range(0, 1 << 23)) - (1 << 22);
      endcase
      return v[COMP_WIDTH-1:0];
   endfunction

   function automatic logic signed [ANG_W-1:0] random_angle();
      int a;
      case ($urandom_range(3))
         0: a = $urandom;                                               // any code
         1: a = int'($urandom_range(0, 2 * TURN_UNITS)) - TURN_UNITS;   // +/-360
         2: a = QUARTER_UNITS * int'($urandom_range(0, 8)) - TURN_UNITS
                + int'($urandom_range(0, 4)) - 2;                       // near folds
         default: a = int'($urandom_range(0, 128)) - 64;                // tiny
      endcase
      return a[ANG_W-1:0];
   endfunction

   task automatic run_random_rotations(input int count);
      pax_axis_type axis;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(7) == 0) axis = AXIS_NONE;
         else axis = pax_axis_type'($urandom_range(2));
         send_vector(make_req(random_component(), random_component(), random_component(),
                              axis, random_angle()));
      end
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin : main_sequence
      int waited;
      waited = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // light sender gaps, heavy receiver stall
      send_idle_pct = 14;
      recv_idle_pct = 70;
      run_pass_through();
      run_zero_angle();
      run_quadrant_edges();
      run_angle_wrap();
      run_saturation();
      run_random_rotations(375);

      // heavy sender gaps, light receiver stall
      send_idle_pct = 70;
      recv_idle_pct = 14;
      run_random_rotations(375);

      // back to back at full rate
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_rotations(380);
      req_valid <= 1'b0;

      // let the pipeline empty
      while (pending_vectors.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_vectors.size() != 0) begin
         $display("tb failed");
         $finish;
      end else begin
         // watch for stray results after the last expected one
         repeat (SETTLE_CYCLES) @(posedge clock);
         if (mismatch_count == 0)
            $display("tb passed");
         else
            $display("tb failed");
         $finish;
      end
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5ms;
      $display("tb failed");
      $finish;
   end

endmodule
